/* rtl/sdc_pkg.sv */
// ----------------------------------------------------------------------------
// sdc_pkg
// Types, constants and the base classifier shared by the SNP distance counter.
// ----------------------------------------------------------------------------
package sdc_pkg;

    localparam int COUNT_BITS    = 25;
    localparam int CHAR_WIDTH    = 8;
    localparam int CUTOFF_WIDTH  = 24;
    localparam int DIST_WIDTH    = 25;
    localparam int LIMIT_WIDTH   = (COUNT_BITS > CUTOFF_WIDTH + 1) ? COUNT_BITS
                                                                   : CUTOFF_WIDTH + 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CUTOFF_WIDTH-1:0] CUTOFF_RESET = {CUTOFF_WIDTH{1'b1}};

    localparam logic [CHAR_WIDTH-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_C    = 8'h43;
    localparam logic [CHAR_WIDTH-1:0] CHAR_G    = 8'h47;
    localparam logic [CHAR_WIDTH-1:0] CHAR_T    = 8'h54;
    localparam logic [CHAR_WIDTH-1:0] CHAR_N    = 8'h4E;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DASH = 8'h2D;

    localparam logic [2:0] CLASS_REF     = 3'd0;
    localparam logic [2:0] CLASS_A       = 3'd1;
    localparam logic [2:0] CLASS_C       = 3'd2;
    localparam logic [2:0] CLASS_G       = 3'd3;
    localparam logic [2:0] CLASS_T       = 3'd4;
    localparam logic [2:0] CLASS_UNKNOWN = 3'd5;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] ref_char;
        logic [CHAR_WIDTH-1:0] first_char;
        logic [CHAR_WIDTH-1:0] second_char;
        logic                  masked;
        logic                  last_position;
    } item_t;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] distance;
        logic                  over_cutoff;
    } result_t;

    // classified position handed from front to back
    typedef struct packed {
        logic hit;
        logic last;
    } token_t;

    function automatic logic [2:0] classify(input logic [CHAR_WIDTH-1:0] ref_base,
                                            input logic [CHAR_WIDTH-1:0] b);
        logic [2:0] cls;
        if (b == ref_base)
        begin
            cls = CLASS_REF;
        end
        else
        begin
            case (b)
                CHAR_A:    cls = CLASS_A;
                CHAR_C:    cls = CLASS_C;
                CHAR_G:    cls = CLASS_G;
                CHAR_T:    cls = CLASS_T;
                CHAR_N:    cls = CLASS_UNKNOWN;
                CHAR_DASH: cls = CLASS_UNKNOWN;
                default:   cls = CLASS_REF;
            endcase
        end
        return cls;
    endfunction

endpackage

/* rtl/sdc_front.sv */
// ----------------------------------------------------------------------------
// sdc_front
// Classifies both sample bases of a position and decides whether it counts.
// ----------------------------------------------------------------------------
module sdc_front
    import sdc_pkg::*;
(
    input  item_t  item,
    output token_t token
);

    logic [2:0] first_cls;
    logic [2:0] second_cls;

    assign first_cls  = classify(item.ref_char, item.first_char);
    assign second_cls = classify(item.ref_char, item.second_char);

    assign token.hit  = !item.masked
                        && (first_cls != CLASS_UNKNOWN)
                        && (second_cls != CLASS_UNKNOWN)
                        && (first_cls != second_cls);
    assign token.last = item.last_position;

endmodule

/* rtl/sdc_queue.sv */
// ----------------------------------------------------------------------------
// sdc_queue
// Short register queue between the classifier and the counter.
// ----------------------------------------------------------------------------
module sdc_queue
    import sdc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  token_t wr_data,
    output logic   wr_full,
    input  logic   rd_en,
    output token_t rd_data,
    output logic   rd_valid
);

    token_t                    mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] cnt_reg;
    logic                      do_wr;
    logic                      do_rd;

    assign wr_full  = (cnt_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !wr_full;
    assign do_rd    = rd_en && rd_valid;

    function automatic logic [QUEUE_PTR_BITS-1:0] ptr_inc(
        input logic [QUEUE_PTR_BITS-1:0] p);
        logic [QUEUE_PTR_BITS-1:0] n;
        if (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/sdc_back.sv */
// ----------------------------------------------------------------------------
// sdc_back
// Saturating distance counter, cutoff register and result register.
// ----------------------------------------------------------------------------
module sdc_back
    import sdc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CUTOFF_WIDTH-1:0] cfg_data,
    input  logic                    tok_valid,
    input  token_t                  tok,
    output logic                    tok_ready,
    output result_t                 result,
    output logic                    empty,
    input  logic                    pop,
    output logic [COUNT_BITS-1:0]   count_mon,
    output logic [CUTOFF_WIDTH-1:0] cutoff_mon
);

    localparam logic [LIMIT_WIDTH-1:0] COUNT_MAX =
        LIMIT_WIDTH'({COUNT_BITS{1'b1}});

    logic [CUTOFF_WIDTH-1:0] cutoff_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;
    logic                    res_valid_reg;
    result_t                 res_reg;
    result_t                 res_next;
    logic [LIMIT_WIDTH-1:0]  cut_plus;
    logic [LIMIT_WIDTH-1:0]  limit;
    logic [LIMIT_WIDTH-1:0]  count_w;
    logic [LIMIT_WIDTH-1:0]  after_w;
    logic [LIMIT_WIDTH-1:0]  dist_w;
    logic                    take;

    assign cut_plus = LIMIT_WIDTH'(cutoff_reg) + 1'b1;
    assign limit    = (cut_plus < COUNT_MAX) ? cut_plus : COUNT_MAX;
    assign count_w  = LIMIT_WIDTH'(count_reg);
    assign after_w  = (tok.hit && (count_w < limit)) ? count_w + 1'b1 : count_w;
    assign dist_w   = (after_w < limit) ? after_w : limit;

    assign tok_ready = !tok.last || !res_valid_reg || pop;
    assign take      = tok_valid && tok_ready;

    assign count_next           = tok.last ? '0 : COUNT_BITS'(after_w);
    assign res_next.distance    = DIST_WIDTH'(dist_w);
    assign res_next.over_cutoff = (dist_w > LIMIT_WIDTH'(cutoff_reg));

    assign result     = res_reg;
    assign empty      = !res_valid_reg;
    assign count_mon  = count_reg;
    assign cutoff_mon = cutoff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg    <= CUTOFF_RESET;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cutoff_reg <= cfg_data;
            end
            if (take)
            begin
                count_reg <= count_next;
            end
            if (take && tok.last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && tok.last)
        begin
            res_reg <= res_next;
        end
    end

endmodule

/* rtl/snp_distance_counter.sv */
// ----------------------------------------------------------------------------
// snp_distance_counter
// SNP distance between two aligned genomes with unknown-base masking.
// ----------------------------------------------------------------------------
// One aligned position is taken per cycle while full is low. A position is
// classified on transfer and held in a two-entry queue; the counter retires
// one queued position per cycle when not stalled, so the sustained rate is
// then one item per clock. The result is registered as the last one retires.
// The result sits in a single output register; the counter stalls on a
// last position only while an earlier result has not been popped.
// ----------------------------------------------------------------------------
module snp_distance_counter
    import sdc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  item_t                   item,
    output logic                    empty,
    input  logic                    pop,
    output result_t                 result,
    input  logic                    cfg_we,
    input  logic [CUTOFF_WIDTH-1:0] cfg_data
);

    token_t                  front_tok;
    token_t                  q_tok;
    logic                    q_valid;
    logic                    q_ready;
    logic [COUNT_BITS-1:0]   count_mon;
    logic [CUTOFF_WIDTH-1:0] cutoff_mon;

    sdc_front u_front
    (
        .item  (item),
        .token (front_tok)
    );

    sdc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (front_tok),
        .wr_full  (full),
        .rd_en    (q_ready),
        .rd_data  (q_tok),
        .rd_valid (q_valid)
    );

    sdc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .tok_valid  (q_valid),
        .tok        (q_tok),
        .tok_ready  (q_ready),
        .result     (result),
        .empty      (empty),
        .pop        (pop),
        .count_mon  (count_mon),
        .cutoff_mon (cutoff_mon)
    );

    // count holds once it is at or above cutoff plus one
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && !q_tok.last
         && (LIMIT_WIDTH'(count_mon) >= (LIMIT_WIDTH'(cutoff_mon) + 1'b1)))
        |=> $stable(count_mon))
        else $error("running count grew beyond saturation limit");

    // a retired last position clears the count
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && q_tok.last) |=> (count_mon == '0))
        else $error("count not cleared after last position");

    // a retired last position always leaves a result waiting
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && q_tok.last) |=> !empty)
        else $error("last position produced no result");

endmodule
